// ===== src/tdtr_pkg.sv =====
// tdtr_pkg: shared types and constants for the tile dedup / tilemap remap block
// no dependencies
package tdtr_pkg;

  localparam int WordW = 64;
  localparam int IdxW  = 10;
  localparam int CntW  = 11;

  localparam logic       OP_TILE  = 1'b0;
  localparam logic       OP_ENTRY = 1'b1;
  localparam logic       KIND_CLASS = 1'b0;
  localparam logic       KIND_ENTRY = 1'b1;

  localparam logic [9:0] REBASE_ADD  = 10'h0C0;
  localparam logic [9:0] REBASE_SUB  = 10'h040;
  localparam logic [3:0] PAL_BIAS    = 4'd3;

  typedef struct packed {
    logic        op;
    logic [63:0] data_word;
    logic        last_word;
    logic [15:0] map_entry;
  } in_word_t;

  typedef struct packed {
    logic        kind;
    logic [9:0]  raw_index;
    logic [9:0]  tile_index;
    logic        is_new;
    logic        full_res;
    logic [15:0] converted_entry;
  } out_word_t;

  // job handed from front to back: a full tile or an entry to convert
  typedef struct packed {
    logic        op;
    logic [3:0][63:0] tile;
    logic [15:0] map_entry;
  } job_t;

endpackage

// ===== src/tdtr_front.sv =====
// tdtr_front: assembles tile words and queues finished jobs
// depends on tdtr_pkg
module tdtr_front import tdtr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_data,
  output logic     job_valid,
  input  logic     job_take,
  output job_t     job_data
);

  logic [1:0]       pos_r, pos_nxt;
  logic [3:0][63:0] asm_r;
  // two-entry queue
  job_t             q_r [2];
  logic             rd_r, wr_r;
  logic [1:0]       cnt_r;
  logic             acc, done_tile, push;
  job_t             nj;

  assign in_stall = (cnt_r == 2'd2);
  assign acc      = in_valid && !in_stall;
  assign done_tile = (in_data.op == OP_TILE) && (in_data.last_word || pos_r == 2'd3);
  assign push     = acc && ((in_data.op == OP_ENTRY) || done_tile);
  assign pos_nxt  = (acc && in_data.op == OP_TILE) ? (done_tile ? 2'd0 : pos_r + 2'd1) : pos_r;

  always_comb begin
    nj = '0;
    nj.op = in_data.op;
    nj.map_entry = in_data.map_entry;
    for (int w = 0; w < 4; w++) begin
      if (w < int'(pos_r)) nj.tile[w] = asm_r[w];
      else if (w == int'(pos_r)) nj.tile[w] = in_data.data_word;
      else nj.tile[w] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_data.op == OP_TILE) asm_r[pos_r] <= in_data.data_word;
    if (push) q_r[wr_r] <= nj;
    if (!rst_n) begin
      pos_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      if (push) wr_r <= ~wr_r;
      if (job_take) rd_r <= ~rd_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, job_take};
    end
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job_data  = q_r[rd_r];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd2 |-> !push) else $error("queue overflow");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid) else $error("take from empty queue");
  a_pos_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    push && in_data.op == OP_TILE |=> pos_r == 2'd0) else $error("word slot not reset");
`endif

endmodule

// ===== src/tdtr_back.sv =====
// tdtr_back: searches the unique store, updates the index map, converts entries
// depends on tdtr_pkg
module tdtr_back import tdtr_pkg::*; #(
  parameter int MaxTiles = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      job_valid,
  output logic      job_take,
  input  job_t      job_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  localparam int SW = $clog2(MaxTiles);
  localparam logic [2:0] S_IDLE = 3'd0, S_RD = 3'd1, S_CMP = 3'd2, S_WR = 3'd3,
                         S_MAP = 3'd4, S_CONV = 3'd5, S_CLR = 3'd6;
  // classification answer when the raw count or the store is used up
  localparam out_word_t FULL_WORD = '{kind: KIND_CLASS, raw_index: '0, tile_index: '0,
                                      is_new: 1'b0, full_res: 1'b1, converted_entry: '0};

  logic [2:0]       st_r;
  logic [CntW-1:0]  uniq_r, raw_r, k_r;
  logic [IdxW-1:0]  clr_r;
  logic [255:0]     store [MaxTiles];
  logic [IdxW-1:0]  imap [1024];
  logic [255:0]     rd_q;
  logic [IdxW-1:0]  map_q;
  logic             ov_r;
  out_word_t        ov_d;
  job_t             j_r;
  logic             hit;
  logic [10:0]      sum;
  logic [9:0]       reb;
  logic [2:0]       pal;

  assign hit = (rd_q == j_r.tile);
  assign out_valid = ov_r;
  assign out_data  = ov_d;
  assign job_take  = (st_r == S_IDLE) && job_valid && !ov_r;
  assign sum = {1'b0, map_q} + {1'b0, REBASE_ADD};
  assign reb = sum[10] ? REBASE_SUB : sum[9:0];
  assign pal = j_r.map_entry[12:10];

  always_ff @(posedge clk) begin
    rd_q  <= store[k_r[SW-1:0]];
    // map read for an entry starts at the edge that takes it
    map_q <= imap[(st_r == S_CLR) ? clr_r :
                  (job_take ? job_data.map_entry[9:0] : j_r.map_entry[9:0])];
    if (st_r == S_WR) store[uniq_r[SW-1:0]] <= j_r.tile;
    if (st_r == S_CLR) imap[clr_r] <= '0;
    else if (st_r == S_MAP) imap[raw_r[IdxW-1:0]] <= ov_d.tile_index;
  end

  always_ff @(posedge clk) begin
    if (job_take) j_r <= job_data;
    if (!rst_n) begin
      st_r   <= S_CLR;
      clr_r  <= '0;
      uniq_r <= '0;
      raw_r  <= '0;
      k_r    <= '0;
      ov_r   <= 1'b0;
    end else begin
      if (ov_r && !out_stall) ov_r <= 1'b0;
      unique case (st_r)
        S_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) st_r <= S_IDLE;
        end
        S_IDLE: begin
          k_r <= '0;
          if (job_take) st_r <= (job_data.op == OP_ENTRY) ? S_CONV : S_RD;
        end
        S_RD: begin
          if (raw_r >= CntW'(MaxTiles)) begin
            ov_d <= FULL_WORD;
            ov_r <= 1'b1;
            st_r <= S_IDLE;
          end else if (k_r >= uniq_r) begin
            if (uniq_r >= CntW'(MaxTiles)) begin
              ov_d <= FULL_WORD;
              ov_r <= 1'b1;
              st_r <= S_IDLE;
            end else begin
              ov_d <= '0;
              st_r <= S_WR;
            end
          end else begin
            ov_d <= '0;
            st_r <= S_CMP;
          end
        end
        S_CMP: begin
          if (hit) begin
            ov_d.raw_index  <= raw_r[IdxW-1:0];
            ov_d.tile_index <= k_r[IdxW-1:0];
            st_r <= S_MAP;
          end else begin
            k_r  <= k_r + 1'b1;
            st_r <= S_RD;
          end
        end
        S_WR: begin
          ov_d.raw_index  <= raw_r[IdxW-1:0];
          ov_d.tile_index <= uniq_r[IdxW-1:0];
          ov_d.is_new     <= 1'b1;
          uniq_r <= uniq_r + 1'b1;
          st_r <= S_MAP;
        end
        S_MAP: begin
          raw_r <= raw_r + 1'b1;
          ov_r  <= 1'b1;
          st_r  <= S_IDLE;
        end
        S_CONV: begin
          ov_d <= '{kind: KIND_ENTRY, raw_index: '0, tile_index: '0,
                    is_new: 1'b0, full_res: 1'b0,
                    converted_entry: {4'({1'b0, pal} + PAL_BIAS),
                                      j_r.map_entry[15:14], reb}};
          ov_r <= 1'b1;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_uniq_le_raw: assert property (@(posedge clk) disable iff (!rst_n)
    st_r != S_MAP |-> uniq_r <= raw_r) else $error("unique count above raw count");
  a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |=> st_r == S_RD || st_r == S_CONV) else $error("job lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r) else $error("result dropped");
`endif

endmodule

// ===== src/tile_dedup_and_tilemap_remap.sv =====
// tile_dedup_and_tilemap_remap: top level joining word assembly and search engine
// depends on tdtr_pkg, tdtr_front, tdtr_back
//
// a tile comes in as four 64-bit words (a last mark ends it early, missing
// words read zero); once complete it is searched against stored unique tiles,
// one store read and one compare per stored tile. a two-job queue between
// assembly and search keeps input words flowing during a search. after reset
// the index map's 1024 entries are cleared, during which queued jobs wait.
module tile_dedup_and_tilemap_remap import tdtr_pkg::*; #(
  parameter int MaxTiles = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  logic job_valid, job_take;
  job_t job_data;

  // word assembly and queue
  tdtr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .job_valid, .job_take, .job_data
  );

  // search, store update and entry conversion
  tdtr_back #(.MaxTiles(MaxTiles)) u_back (
    .clk, .rst_n, .job_valid, .job_take, .job_data,
    .out_valid, .out_stall, .out_data
  );

endmodule

// ===== tb/tb_top.sv =====
// tb_top: self-checking testbench for tile_dedup_and_tilemap_remap
// depends on tdtr_pkg and the block's rtl; drives random and directed words
// and checks results against an in-bench model of the dedup and remap logic
module tb_top;
  import tdtr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MapDepth   = 1024;
  localparam int TileLimit  = 1024;
  localparam int CycleLimit = 4000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;

  tile_dedup_and_tilemap_remap i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // ---------------------------------------------------------------
  // model state: assembly buffer, unique tiles, raw -> unique map
  // ---------------------------------------------------------------
  logic [63:0]      asm_buf [4];
  int unsigned      asm_pos;
  logic [3:0][63:0] uniq_tiles [TileLimit];
  int unsigned      uniq_cnt;
  int unsigned      raw_cnt;
  logic [9:0]       idx_map [MapDepth];

  out_word_t pending_results[$];   // expected results, oldest first
  in_word_t  word_fifo[$];         // words waiting to be driven
  int        err_cnt;

  // work out what one accepted word produces, update model state
  function automatic void predict_word(input in_word_t w);
    out_word_t        r;
    logic [3:0][63:0] t;
    logic [9:0]       mapped;
    int unsigned      hit_idx;
    bit               hit;
    r = '0;
    if (w.op == OP_ENTRY) begin
      mapped = idx_map[w.map_entry[9:0]];
      if (int'(mapped) + 'h0C0 > 'h3FF) mapped = 10'h040;
      else mapped = mapped + 10'h0C0;
      r.kind = KIND_ENTRY;
      r.converted_entry = {4'(w.map_entry[12:10] + 3'd0 + 4'd3), w.map_entry[15:14], mapped};
      pending_results = {pending_results, r};
      return;
    end
    asm_buf[asm_pos] = w.data_word;
    if (!w.last_word && asm_pos < 3) begin
      asm_pos++;
      return;
    end
    for (int i = 0; i < 4; i++) t[i] = (i <= asm_pos) ? asm_buf[i] : 64'd0;
    asm_pos = 0;
    r.kind = KIND_CLASS;
    if (raw_cnt >= TileLimit) begin
      r.full_res = 1'b1;
      pending_results = {pending_results, r};
      return;
    end
    hit = 0;
    hit_idx = 0;
    for (int k = 0; k < uniq_cnt; k++) begin
      if (uniq_tiles[k] == t) begin
        hit = 1;
        hit_idx = k;
        break;
      end
    end
    if (!hit) begin
      hit_idx = uniq_cnt;
      uniq_tiles[uniq_cnt] = t;
      uniq_cnt++;
      r.is_new = 1'b1;
    end
    idx_map[raw_cnt[9:0]] = hit_idx[9:0];
    r.raw_index  = raw_cnt[9:0];
    r.tile_index = hit_idx[9:0];
    raw_cnt++;
    pending_results = {pending_results, r};
  endfunction

  // ---------------------------------------------------------------
  // stimulus building
  // ---------------------------------------------------------------
  typedef struct packed {
    logic [3:0][63:0] w;
    logic [2:0]       n;
  } sent_tile_t;

  sent_tile_t sent_tiles[$];
  int         tiles_queued;

  function automatic logic [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_entry(input logic [15:0] e);
    in_word_t w;
    w = '0;
    w.op = OP_ENTRY;
    w.map_entry = e;
    w.data_word = rand_word();      // ignored for entries, random anyway
    w.last_word = 1'($urandom_range(0, 1));
    word_fifo = {word_fifo, w};
  endfunction

  // queue the words of one tile; a four-word tile may leave the last mark off
  function automatic void queue_tile(input sent_tile_t t, input bit mark4);
    in_word_t w;
    for (int i = 0; i < t.n; i++) begin
      w = '0;
      w.op = OP_TILE;
      w.data_word = t.w[i];
      w.last_word = (i == t.n - 1) ? ((t.n == 4) ? mark4 : 1'b1) : 1'b0;
      w.map_entry = 16'($urandom);
      word_fifo = {word_fifo, w};
    end
    sent_tiles = {sent_tiles, t};
    tiles_queued++;
  endfunction

  function automatic sent_tile_t fresh_tile(input int n);
    sent_tile_t t;
    t = '0;
    t.n = 3'(n);
    for (int i = 0; i < n; i++) t.w[i] = rand_word();
    return t;
  endfunction

  task automatic build_stimulus();
    sent_tile_t t;
    int         pick;
    // directed: entries before any tile read the cleared map
    queue_entry(16'h0000);
    queue_entry(16'hFFFF);
    // full four-word tile, no last mark: fourth word completes it
    t = fresh_tile(4);
    queue_tile(t, 1'b0);
    queue_tile(t, 1'b1);            // duplicate, marked this time
    // short tiles: one word all ones, one word all zeros, two and three words
    t = '0; t.n = 1; t.w[0] = '1;
    queue_tile(t, 1'b1);
    t = '0; t.n = 1;
    queue_tile(t, 1'b1);
    t = '0; t.n = 4;                // same as zero short tile, padded
    queue_tile(t, 1'b0);
    queue_tile(fresh_tile(2), 1'b1);
    queue_tile(fresh_tile(3), 1'b1);
    queue_entry(16'h0001);
    queue_entry(16'hDC02);          // flips, palette 7, bit 13 clear
    queue_entry(16'h4403);
    queue_entry(16'h8005);
    queue_entry(16'h03FF);
    // random: mostly new tiles
    while (word_fifo.size() < 500) begin
      if ($urandom_range(0, 5) == 0)
        queue_entry(16'($urandom));
      else if ($urandom_range(0, 9) == 0)
        queue_tile(sent_tiles[$urandom_range(0, sent_tiles.size() - 1)],
                   1'($urandom_range(0, 1)));
      else
        queue_tile(fresh_tile($urandom_range(0, 3) == 0 ? $urandom_range(2, 4) : 1),
                   1'($urandom_range(0, 1)));
    end
    // entries whose raw index points at recently classified tiles
    for (int i = 0; i < 12; i++)
      queue_entry(16'($urandom_range(tiles_queued - 60, tiles_queued - 1)) |
                  16'($urandom) & 16'hFC00);
    // cheap duplicates of early tiles
    while (word_fifo.size() < 566) begin
      if ($urandom_range(0, 3) == 0) queue_entry(16'($urandom));
      pick = $urandom_range(0, 15);
      queue_tile(sent_tiles[pick], 1'($urandom_range(0, 1)));
    end
    for (int i = 0; i < 6; i++) queue_entry(16'($urandom));
    queue_tile(fresh_tile(4), 1'b0);
  endtask

  // ---------------------------------------------------------------
  // driver: one word per acceptance, random gaps with calm stretches
  // ---------------------------------------------------------------
  int send_gap;
  int send_calm;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
      send_calm = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) predict_word(in_data);
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (word_fifo.size() > 0) begin
        in_data  <= word_fifo.pop_front();
        in_valid <= 1'b1;
        if (send_calm > 0) send_calm--;
        else if ($urandom_range(0, 40) == 0) send_calm = $urandom_range(20, 60);
        send_gap = (send_calm > 0) ? 0 : $urandom_range(0, 6);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------
  // monitor: compare each accepted result with the oldest expectation
  // ---------------------------------------------------------------
  int        recv_wait;
  int        recv_hold;
  int        results_seen;
  bit        hold_done;
  out_word_t exp_r;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      recv_hold = 0;
      results_seen = 0;
      hold_done = 0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %h", out_data);
          err_cnt++;
        end else begin
          exp_r = pending_results.pop_front();
          if (out_data.kind != exp_r.kind) begin
            $error("kind exp %0d got %0d", exp_r.kind, out_data.kind); err_cnt++;
          end
          if (out_data.raw_index != exp_r.raw_index) begin
            $error("raw_index exp %0d got %0d", exp_r.raw_index, out_data.raw_index);
            err_cnt++;
          end
          if (out_data.tile_index != exp_r.tile_index) begin
            $error("tile_index exp %0d got %0d", exp_r.tile_index, out_data.tile_index);
            err_cnt++;
          end
          if (out_data.is_new != exp_r.is_new) begin
            $error("is_new exp %0d got %0d", exp_r.is_new, out_data.is_new); err_cnt++;
          end
          if (out_data.full_res != exp_r.full_res) begin
            $error("full_res exp %0d got %0d", exp_r.full_res, out_data.full_res);
            err_cnt++;
          end
          if (out_data.converted_entry != exp_r.converted_entry) begin
            $error("converted_entry exp %h got %h", exp_r.converted_entry,
                   out_data.converted_entry);
            err_cnt++;
          end
        end
        recv_wait = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      end else if (recv_wait > 0) begin
        recv_wait--;
      end
      // one long hold-off so the internal queue fills and input stalls
      if (!hold_done && results_seen == 40) begin
        hold_done = 1;
        recv_hold = 3000;
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold > 0) || (recv_wait > 0);
    end
  end

  // ---------------------------------------------------------------
  // run control
  // ---------------------------------------------------------------
  int cycle_cnt;

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    err_cnt   = 0;
    cycle_cnt = 0;
    asm_pos   = 0;
    uniq_cnt  = 0;
    raw_cnt   = 0;
    tiles_queued = 0;
    for (int i = 0; i < MapDepth; i++) idx_map[i] = '0;
    build_stimulus();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // all words accepted, then every expected result back
    do @(posedge clk); while (word_fifo.size() > 0 || in_valid);
    do @(posedge clk); while (pending_results.size() > 0);
    repeat (50) @(posedge clk);
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule

// ===== filelist.f =====
src/tdtr_pkg.sv
src/tdtr_front.sv
src/tdtr_back.sv
src/tile_dedup_and_tilemap_remap.sv
tb/tb_top.sv
